### rtl/csvs_pkg.sv
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types and constants for the CSV record and field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    // one result beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       field_end;
        logic       record_end;
        logic       end_of_data;
    } res_t;

    // results caused by one input byte: one or two
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    typedef struct packed {
        logic stopped;
        logic push;
    } front_status_t;

endpackage

### rtl/csvs_front.sv
// ----------------------------------------------------------------------------
// csvs_front
// Accepts input beats, runs the record and field trackers and packs the
// results of each byte into one queue entry.
// ----------------------------------------------------------------------------
module csvs_front
    import csvs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          kind,
    input  logic [7:0]    byte_in,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    output logic          q_push,
    output entry_t        q_data,
    output front_status_t status
);

    logic       rec_quoted_reg, rec_quoted_next;
    logic       rec_escape_reg, rec_escape_next;
    logic       fld_quoted_reg, fld_quoted_next;
    logic       fld_escape_reg, fld_escape_next;
    logic       pending_cr_reg, pending_cr_next;
    logic       last_cr_reg, last_cr_next;
    logic       stopped_reg, stopped_next;
    logic [1:0] count_reg, count_next;
    logic [7:0] delim_reg;

    logic   ends;
    logic   fld_emit;
    res_t   fld_res;
    res_t   cr_res;
    logic   n_any;
    entry_t ent;

    always_comb
    begin
        cr_res            = '0;
        cr_res.data_byte  = CH_CR;
        cr_res.data_valid = 1'b1;
    end

    always_comb
    begin
        rec_quoted_next = rec_quoted_reg;
        rec_escape_next = rec_escape_reg;
        fld_quoted_next = fld_quoted_reg;
        fld_escape_next = fld_escape_reg;
        pending_cr_next = pending_cr_reg;
        last_cr_next    = last_cr_reg;
        stopped_next    = stopped_reg;
        count_next      = count_reg;
        ends            = 1'b0;
        fld_emit        = 1'b0;
        fld_res         = '0;
        n_any           = 1'b0;
        ent             = '0;

        if (stopped_reg)
        begin
            n_any = 1'b0;
        end
        else if (kind == KIND_END)
        begin
            n_any = 1'b1;
            if (count_reg == 2'd0)
            begin
                ent.r0.end_of_data = 1'b1;
            end
            else if (pending_cr_reg)
            begin
                ent.two            = 1'b1;
                ent.r0             = cr_res;
                ent.r1.field_end   = 1'b1;
                ent.r1.record_end  = 1'b1;
                ent.r1.end_of_data = 1'b1;
            end
            else
            begin
                ent.r0.field_end   = 1'b1;
                ent.r0.record_end  = 1'b1;
                ent.r0.end_of_data = 1'b1;
            end
            rec_quoted_next = 1'b0;
            rec_escape_next = 1'b0;
            fld_quoted_next = 1'b0;
            fld_escape_next = 1'b0;
            pending_cr_next = 1'b0;
            last_cr_next    = 1'b0;
            count_next      = 2'd0;
            stopped_next    = 1'b1;
        end
        else
        begin
            // record tracker
            if (rec_escape_reg)
                rec_escape_next = 1'b0;
            else if (!rec_quoted_reg && byte_in == CH_QUOTE)
                rec_quoted_next = 1'b1;
            else if (byte_in == CH_BSLASH)
                rec_escape_next = 1'b1;
            else if (rec_quoted_reg && byte_in == CH_QUOTE)
                rec_quoted_next = 1'b0;
            else if (!rec_quoted_reg && byte_in == CH_LF)
                ends = 1'b1;

            if (ends)
            begin
                n_any = 1'b1;
                if (count_reg == 2'd0 || (count_reg == 2'd1 && last_cr_reg))
                begin
                    ent.r0.end_of_data = 1'b1;
                    stopped_next       = 1'b1;
                end
                else
                begin
                    ent.r0.field_end  = 1'b1;
                    ent.r0.record_end = 1'b1;
                end
                // drop any open escape or held CR
                rec_quoted_next = 1'b0;
                rec_escape_next = 1'b0;
                fld_quoted_next = 1'b0;
                fld_escape_next = 1'b0;
                pending_cr_next = 1'b0;
                last_cr_next    = 1'b0;
                count_next      = 2'd0;
            end
            else
            begin
                if (count_reg != 2'd3)
                    count_next = count_reg + 2'd1;
                last_cr_next    = (byte_in == CH_CR);
                pending_cr_next = 1'b0;

                // field tracker
                if (fld_escape_reg)
                begin
                    fld_escape_next = 1'b0;
                    if (byte_in == CH_CR)
                        pending_cr_next = 1'b1;
                    else
                        fld_emit = 1'b1;
                end
                else if (byte_in == CH_CR)
                begin
                    fld_emit = 1'b0;
                end
                else if (!fld_quoted_reg && byte_in == CH_QUOTE)
                begin
                    fld_quoted_next = 1'b1;
                end
                else if (fld_quoted_reg)
                begin
                    if (byte_in == CH_BSLASH)
                        fld_escape_next = 1'b1;
                    else if (byte_in == CH_QUOTE)
                        fld_quoted_next = 1'b0;
                    else
                        fld_emit = 1'b1;
                end
                else if (delim_reg != 8'd0 && byte_in == delim_reg)
                begin
                    fld_emit          = 1'b1;
                    fld_res.field_end = 1'b1;
                end
                else
                begin
                    fld_emit = 1'b1;
                end

                if (fld_emit && !fld_res.field_end)
                begin
                    fld_res.data_byte  = byte_in;
                    fld_res.data_valid = 1'b1;
                end

                // a held CR goes out ahead of this byte's result
                if (pending_cr_reg)
                begin
                    n_any   = 1'b1;
                    ent.r0  = cr_res;
                    ent.two = fld_emit;
                    ent.r1  = fld_emit ? fld_res : '0;
                end
                else
                begin
                    n_any  = fld_emit;
                    ent.r0 = fld_res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_quoted_reg <= 1'b0;
            rec_escape_reg <= 1'b0;
            fld_quoted_reg <= 1'b0;
            fld_escape_reg <= 1'b0;
            pending_cr_reg <= 1'b0;
            last_cr_reg    <= 1'b0;
            stopped_reg    <= 1'b0;
            count_reg      <= 2'd0;
        end
        else if (accept)
        begin
            rec_quoted_reg <= rec_quoted_next;
            rec_escape_reg <= rec_escape_next;
            fld_quoted_reg <= fld_quoted_next;
            fld_escape_reg <= fld_escape_next;
            pending_cr_reg <= pending_cr_next;
            last_cr_reg    <= last_cr_next;
            stopped_reg    <= stopped_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delim_reg <= DELIM_RESET;
        else if (cfg_we)
            delim_reg <= cfg_wdata;
    end

    assign q_push         = accept && n_any;
    assign q_data         = ent;
    assign status.stopped = stopped_reg;
    assign status.push    = q_push;

endmodule

### rtl/csvs_queue.sv
// ----------------------------------------------------------------------------
// csvs_queue
// Short register queue of result entries between front and back.
// ----------------------------------------------------------------------------
module csvs_queue
    import csvs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   not_empty,
    output logic   full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);

endmodule

### rtl/csvs_back.sv
// ----------------------------------------------------------------------------
// csvs_back
// Holds one entry and hands out its one or two result beats in order.
// ----------------------------------------------------------------------------
module csvs_back
    import csvs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  entry_t q_data,
    output logic   q_pop,
    input  logic   pop,
    output logic   empty,
    output res_t   res
);

    logic   hold_reg;
    logic   second_reg;
    entry_t ent_reg;
    logic   last;
    logic   take;
    logic   load;

    assign last  = !ent_reg.two || second_reg;
    assign take  = pop && hold_reg;
    assign load  = q_valid && (!hold_reg || (take && last));
    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (load)
        begin
            hold_reg   <= 1'b1;
            second_reg <= 1'b0;
        end
        else if (take && !last)
        begin
            second_reg <= 1'b1;
        end
        else if (take)
        begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= q_data;
    end

    assign empty = !hold_reg;
    assign res   = second_reg ? ent_reg.r1 : ent_reg.r0;

endmodule

### rtl/csv_record_field_splitter_top.sv
// ----------------------------------------------------------------------------
// csv_record_field_splitter_top
// Streaming CSV splitter: raw bytes in, field bytes with field and record
// end marks out.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive kind/byte_in with push, the beat
//   is taken when full is low. kind high marks end of input.
//   Result side is a queue read port: while empty is low the oldest result
//   is on data_byte/data_valid/field_end/record_end/end_of_data; pop takes it.
//   cfg_we/cfg_wdata write the delimiter (reset 44, zero never splits);
//   write it only while the block is idle.
//   Throughput: one input byte per cycle while full is low. A byte yields
//   zero, one or two results; the result port moves one per cycle while pop
//   is high; a two-result byte takes two pops, absorbed by the entry queue.
//   Path: a taken byte's results are written into the queue, then loaded
//   into the back-end holding register, which drives the output; the load
//   waits while the back end still holds an earlier entry.
//   When pop stays low the back end holds its entry, the queue fills and
//   full rises; nothing is lost. After end_of_data the block takes bytes
//   and drops them until reset. Reset clears trackers/queue, delimiter 44.
// ----------------------------------------------------------------------------
module csv_record_field_splitter_top
    import csvs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic [7:0] byte_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic       data_valid,
    output logic       field_end,
    output logic       record_end,
    output logic       end_of_data,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic          accept;
    logic          q_push;
    entry_t        q_wdata;
    entry_t        q_rdata;
    logic          q_valid;
    logic          q_pop;
    logic          q_full;
    front_status_t fst;
    res_t          res;

    assign full   = q_full;
    assign accept = push && !q_full;

    csvs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .byte_in   (byte_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .status    (fst)
    );

    csvs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_data   (q_wdata),
        .rd_en     (q_pop),
        .rd_data   (q_rdata),
        .not_empty (q_valid),
        .full      (q_full)
    );

    csvs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign data_byte   = res.data_byte;
    assign data_valid  = res.data_valid;
    assign field_end   = res.field_end;
    assign record_end  = res.record_end;
    assign end_of_data = res.end_of_data;

`ifndef SYNTHESIS
    a_record_closes_field: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && record_end) |-> field_end)
        else $error("record end without field end");

    a_mark_has_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !data_valid) |-> (data_byte == 8'd0))
        else $error("nonzero byte on a mark beat");

    a_silent_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $past(fst.stopped) |-> !fst.push)
        else $error("front pushed after end of data");
`endif

endmodule

### tb/sv/tb_csv_record_field_splitter_top.sv
// ----------------------------------------------------------------------------
// tb_csv_record_field_splitter_top
// Drives raw CSV bytes into the splitter and checks every result beat against
// a cycle-free predictor of both trackers. Covers directed corner records,
// several delimiter settings (zero, 0xFF and the special bytes among them),
// random well-formed records mixed with noise, and one randomly chosen way of
// stopping the stream, followed by ignored traffic.
// ----------------------------------------------------------------------------
module tb_csv_record_field_splitter_top;
    import csvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // predicts the split of each accepted byte and holds the beats still due
    class split_scoreboard;
        logic [7:0] delim;
        bit         rec_q;
        bit         rec_esc;
        bit         fld_q;
        bit         fld_esc;
        bit         pend_cr;
        bit         last_cr;
        bit         halted;
        int         rec_count;
        int         errors;
        res_t       beats_due[$];

        function new();
            delim  = DELIM_RESET;
            halted = 1'b0;
            errors = 0;
            clear_rec();
        endfunction

        function void clear_rec();
            rec_q     = 1'b0;
            rec_esc   = 1'b0;
            fld_q     = 1'b0;
            fld_esc   = 1'b0;
            pend_cr   = 1'b0;
            last_cr   = 1'b0;
            rec_count = 0;
        endfunction

        function void set_delim(logic [7:0] v);
            delim = v;
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        // true if an LF now would close an empty record and stop the block
        function bit lf_would_stop();
            return !halted && !rec_esc && !rec_q &&
                   (rec_count == 0 || (rec_count == 1 && last_cr));
        endfunction

        function void due(logic [7:0] b, logic v, logic fe, logic re, logic eod);
            res_t r;
            r.data_byte   = b;
            r.data_valid  = v;
            r.field_end   = fe;
            r.record_end  = re;
            r.end_of_data = eod;
            beats_due = {beats_due, r};
        endfunction

        function void take_byte(logic k, logic [7:0] c);
            bit ends;
            ends = 1'b0;
            if (halted)
                return;
            if (k == KIND_END)
            begin
                if (rec_count == 0)
                    due(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                else
                begin
                    if (pend_cr)
                        due(CH_CR, 1'b1, 1'b0, 1'b0, 1'b0);
                    due(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
                end
                clear_rec();
                halted = 1'b1;
                return;
            end

            // record tracker: an unescaped backslash skips the next byte
            if (rec_esc)
                rec_esc = 1'b0;
            else if (!rec_q && c == CH_QUOTE)
                rec_q = 1'b1;
            else if (c == CH_BSLASH)
                rec_esc = 1'b1;
            else if (rec_q && c == CH_QUOTE)
                rec_q = 1'b0;
            else if (!rec_q && c == CH_LF)
                ends = 1'b1;

            if (ends)
            begin
                if (rec_count == 0 || (rec_count == 1 && last_cr))
                begin
                    due(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                    halted = 1'b1;
                end
                else
                    due(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                // a held CR or an open escape dies with the record
                clear_rec();
                return;
            end

            if (rec_count < 3)
                rec_count++;
            last_cr = (c == CH_CR);

            if (pend_cr)
            begin
                due(CH_CR, 1'b1, 1'b0, 1'b0, 1'b0);
                pend_cr = 1'b0;
            end

            // field tracker
            if (fld_esc)
            begin
                fld_esc = 1'b0;
                if (c == CH_CR)
                    pend_cr = 1'b1;
                else
                    due(c, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            else if (c == CH_CR)
            begin
                // drop
            end
            else if (!fld_q && c == CH_QUOTE)
                fld_q = 1'b1;
            else if (fld_q)
            begin
                if (c == CH_BSLASH)
                    fld_esc = 1'b1;
                else if (c == CH_QUOTE)
                    fld_q = 1'b0;
                else
                    due(c, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            else if (delim != 8'h00 && c == delim)
                due(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            else
                due(c, 1'b1, 1'b0, 1'b0, 1'b0);
        endfunction

        function void same(string what, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch: expected %02h, actual %02h",
                         $time, what, exp_v, act_v);
                errors++;
            end
        endfunction

        function void match_beat(res_t got);
            res_t want;
            if (beats_due.size() == 0)
            begin
                $display("%0t: unexpected beat: byte %02h valid %0b fe %0b re %0b eod %0b",
                         $time, got.data_byte, got.data_valid, got.field_end,
                         got.record_end, got.end_of_data);
                errors++;
                return;
            end
            want = beats_due.pop_front();
            same("data_byte", want.data_byte, got.data_byte);
            same("data_valid", want.data_valid, got.data_valid);
            same("field_end", want.field_end, got.field_end);
            same("record_end", want.record_end, got.record_end);
            same("end_of_data", want.end_of_data, got.end_of_data);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic       kind;
    logic [7:0] byte_in;
    logic       empty;
    logic       pop;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       field_end;
    logic       record_end;
    logic       end_of_data;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    split_scoreboard board;
    bit              calm;
    int              sent;
    logic [7:0]      cur_delim;

    // corner records under the reset delimiter
    logic [7:0] warmup [21] = '{
        8'h00, 8'hFF, DELIM_RESET, CH_CR, CH_LF,
        CH_QUOTE, DELIM_RESET, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_CR, 8'h78,
        CH_QUOTE, CH_LF,
        CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_CR, CH_LF,
        8'h71, CH_LF
    };

    logic [7:0] delim_plan [11] = '{
        8'h00, 8'hFF, CH_QUOTE, CH_BSLASH, CH_CR, CH_LF, DELIM_RESET,
        8'h09, 8'h3B, 8'h00, DELIM_RESET
    };

    csv_record_field_splitter_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .byte_in     (byte_in),
        .empty       (empty),
        .pop         (pop),
        .data_byte   (data_byte),
        .data_valid  (data_valid),
        .field_end   (field_end),
        .record_end  (record_end),
        .end_of_data (end_of_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_CR;
            3: return CH_LF;
            4: return cur_delim;
            5, 6: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // one input beat; hold it until the block takes it
    task automatic put_beat(input logic k, input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        push    <= 1'b1;
        kind    <= k;
        byte_in <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.take_byte(k, b);
        sent++;
    endtask

    // keep the stream alive: no empty-record LF before the finale
    task automatic send_byte(input logic [7:0] b);
        if (b == CH_LF && board.lf_would_stop())
            b = 8'h2E;
        put_beat(KIND_BYTE, b);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) send_byte(pick_byte());
    endtask

    task automatic send_record();
        int         nf;
        int         len;
        logic [7:0] b;
        nf = $urandom_range(1, 4);
        for (int i = 0; i < nf; i++)
        begin
            if (i > 0)
                send_byte(cur_delim);
            case ($urandom_range(0, 3))
                0:
                begin
                    len = $urandom_range(0, 5);
                    repeat (len) send_byte(8'($urandom_range(8'h30, 8'h7A)));
                end
                1, 2:
                begin
                    send_byte(CH_QUOTE);
                    len = $urandom_range(0, 6);
                    repeat (len)
                    begin
                        b = pick_byte();
                        if (b == CH_QUOTE || b == CH_BSLASH ||
                            (b == CH_CR && $urandom_range(0, 1) == 0))
                            send_byte(CH_BSLASH);
                        send_byte(b);
                    end
                    send_byte(CH_QUOTE);
                end
                default:
                    send_noise();
            endcase
        end
        // close a stray record quote so the terminator can end the record
        if (board.rec_q)
            send_byte(CH_QUOTE);
        if ($urandom_range(0, 2) == 0)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic settle_and_set(input logic [7:0] v);
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // let a byte with no result drain the queue and back end
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_delim(v);
        cur_delim = v;
    endtask

    // bring the record trackers back to a clean record start
    task automatic close_record();
        while (!board.halted && (board.rec_q || board.rec_esc || board.rec_count != 0))
            put_beat(KIND_BYTE, (board.rec_q && !board.rec_esc) ? CH_QUOTE : CH_LF);
    endtask

    // result side: sample at the edge, then pick the next pop
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.match_beat({data_byte, data_valid, field_end, record_end, end_of_data});
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        int phase_goal;
        int finale;
        board     = new();
        calm      = 1'b0;
        sent      = 0;
        cur_delim = DELIM_RESET;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        kind      <= KIND_BYTE;
        byte_in   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_wdata <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (warmup[i])
            send_byte(warmup[i]);

        foreach (delim_plan[p])
        begin
            settle_and_set(p == 8 ? 8'($urandom_range(0, 255)) : delim_plan[p]);
            if (p >= 9)
                calm = 1'b1;
            phase_goal = sent + 130;
            while (sent < phase_goal)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_record();
            end
        end

        // stop the stream one way or another
        finale = $urandom_range(0, 4);
        case (finale)
            0:
                put_beat(KIND_END, 8'($urandom_range(0, 255)));
            1:
            begin
                // held escaped CR flushed by end of input
                put_beat(KIND_BYTE, CH_QUOTE);
                put_beat(KIND_BYTE, CH_BSLASH);
                put_beat(KIND_BYTE, CH_CR);
                put_beat(KIND_END, 8'h00);
            end
            2:
            begin
                close_record();
                put_beat(KIND_END, 8'h00);
            end
            3:
            begin
                close_record();
                put_beat(KIND_BYTE, CH_LF);
            end
            default:
            begin
                close_record();
                put_beat(KIND_BYTE, CH_CR);
                put_beat(KIND_BYTE, CH_LF);
            end
        endcase

        // the block must stay silent now
        repeat (3) put_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
        put_beat(KIND_END, 8'h00);
        push <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/csvs_pkg.sv
rtl/csvs_front.sv
rtl/csvs_queue.sv
rtl/csvs_back.sv
rtl/csv_record_field_splitter_top.sv
tb/sv/tb_csv_record_field_splitter_top.sv
